// ----- sv/assert_macros.svh -----
// assertion helpers for the interval set block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ----- sv/isui_pkg.sv -----
package isui_pkg;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_CLEAR,
    CMD_INSERT,
    CMD_MERGE,
    CMD_SQUEEZE
  } cell_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SQUEEZE,
    ST_OUT
  } ctrl_state_t;

  // flags a cell shows to its neighbours and to the controller
  typedef struct packed {
    logic valid;
    logic dead;
    logic tail;
    logic covered;
    logic meet;
    logic place;
  } cell_flags_t;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_ORDER = 2'd2;

  // what sits beyond either end of the row
  localparam cell_flags_t LEFT_EDGE  = '{valid: 1'b0, dead: 1'b0, tail: 1'b0,
                                         covered: 1'b0, meet: 1'b0, place: 1'b0};
  localparam cell_flags_t RIGHT_EDGE = '{valid: 1'b0, dead: 1'b0, tail: 1'b1,
                                         covered: 1'b0, meet: 1'b0, place: 1'b1};

endpackage

// ----- sv/interval_set_union_insert_unit.sv -----
// a request is captured on the input beat, then evaluated, and its result is registered on m_tdata
// a merge that joins k >= 2 stored intervals first drops each absorbed cell in ST_SQUEEZE, then checks the row
// a new request is taken only in ST_IDLE, not while the last one is evaluated; a held result blocks input
// reset (rst, synchronous): the set is emptied and no result is pending
// interval coordinates stay undefined until written and are never read while invalid
`include "assert_macros.svh"

module interval_set_union_insert_unit #(
  parameter int MAX_INTERVALS = 16,
  parameter int COORD_BITS    = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // span_low [31:0], span_high [63:32]
  input  logic        s_tuser,   // func: 0 insert, 1 clear
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata    // added [0], status [2:1], stored_count [7:3]
);
  import isui_pkg::*;

  localparam int CW = $clog2(MAX_INTERVALS + 1);

  ctrl_state_t state, state_next;
  cell_cmd_t   cmd;

  // request captured on the input beat
  logic signed [COORD_BITS-1:0] req_lo, req_hi;
  logic                         req_clear;

  logic [CW-1:0] count, count_next;
  logic          res_added, res_added_next;
  logic [1:0]    res_status, res_status_next;
  logic          out_free, load_out;

  // cell row
  cell_flags_t                  fl [MAX_INTERVALS];
  logic signed [COORD_BITS-1:0] st [MAX_INTERVALS];
  logic signed [COORD_BITS-1:0] en [MAX_INTERVALS];

  logic [MAX_INTERVALS-1:0] valid_vec, dead_vec, cov_vec, meet_vec, first_vec, multi_vec;
  logic [MAX_INTERVALS:0]   valid_plus;

  for (genvar i = 0; i < MAX_INTERVALS; i++) begin : g_cell
    cell_flags_t                  lf, rf;
    logic signed [COORD_BITS-1:0] ls, le, rs, re;

    if (i == 0) begin : g_left_edge
      assign lf = LEFT_EDGE;
      assign ls = '0;
      assign le = '0;
    end else begin : g_left
      assign lf = fl[i-1];
      assign ls = st[i-1];
      assign le = en[i-1];
    end

    if (i == MAX_INTERVALS - 1) begin : g_right_edge
      assign rf = RIGHT_EDGE;
      assign rs = '0;
      assign re = '0;
    end else begin : g_right
      assign rf = fl[i+1];
      assign rs = st[i+1];
      assign re = en[i+1];
    end

    isui_cell #(
      .COORD_BITS(COORD_BITS)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .req_lo     (req_lo),
      .req_hi     (req_hi),
      .left_flags (lf),
      .left_start (ls),
      .left_end   (le),
      .right_flags(rf),
      .right_start(rs),
      .right_end  (re),
      .flags      (fl[i]),
      .start_q    (st[i]),
      .end_q      (en[i])
    );
  end

  // per-cell flags gathered for the controller
  always_comb begin
    for (int i = 0; i < MAX_INTERVALS; i++) begin
      valid_vec[i] = fl[i].valid;
      dead_vec[i]  = fl[i].dead;
      cov_vec[i]   = fl[i].covered;
      meet_vec[i]  = fl[i].meet;
      if (i == 0) begin
        first_vec[i] = fl[i].meet;
        multi_vec[i] = 1'b0;
      end else begin
        first_vec[i] = fl[i].meet && !fl[i-1].meet;
        multi_vec[i] = fl[i].meet && fl[i-1].meet;
      end
    end
  end

  assign valid_plus = {1'b0, valid_vec} + 1'b1;

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  // controller: evaluate once, then drop absorbed cells one per cycle
  always_comb begin
    state_next      = state;
    cmd             = CMD_HOLD;
    count_next      = count;
    res_added_next  = res_added;
    res_status_next = res_status;
    load_out        = 1'b0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        res_added_next  = 1'b0;
        res_status_next = STATUS_OK;
        if (req_clear) begin
          cmd        = CMD_CLEAR;
          count_next = '0;
        end else if (req_lo > req_hi) begin
          res_status_next = STATUS_ORDER;
        end else if (|cov_vec) begin
          // already covered, nothing to do
        end else if (!(|meet_vec)) begin
          if (count == CW'(MAX_INTERVALS)) begin
            res_status_next = STATUS_FULL;
          end else begin
            cmd            = CMD_INSERT;
            count_next     = count + 1'b1;
            res_added_next = 1'b1;
          end
        end else begin
          cmd            = CMD_MERGE;
          res_added_next = 1'b1;
        end
        if (cmd == CMD_MERGE && (|multi_vec)) begin
          state_next = ST_SQUEEZE;
        end else if (out_free) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end else begin
          state_next = ST_OUT;
        end
      end
      ST_SQUEEZE: begin
        if (|dead_vec) begin
          cmd        = CMD_SQUEEZE;
          count_next = count - 1'b1;
        end else if (out_free) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end else begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
    if (s_tvalid && s_tready) begin
      req_lo    <= COORD_BITS'($signed(s_tdata[31:0]));
      req_hi    <= COORD_BITS'($signed(s_tdata[63:32]));
      req_clear <= s_tuser;
    end
    res_added  <= res_added_next;
    res_status <= res_status_next;
    if (load_out) begin
      m_tdata <= {5'(count_next), res_status_next, res_added_next};
    end
  end

  // valid cells always form a prefix of the row
  `ASSERT_CLK(a_valid_prefix, $onehot(valid_plus), "valid cells are not packed low")
  // the count register tracks the valid cells between requests
  `ASSERT_IMPL(a_count_match, state == ST_IDLE, $countones(valid_vec) == count, "count out of step")
  // the request meets at most one run of stored intervals
  `ASSERT_IMPL(a_single_run, state == ST_EVAL, $onehot0(first_vec), "meeting cells not contiguous")
  // no absorbed cell survives a finished merge
  `ASSERT_IMPL(a_no_dead_idle, state == ST_IDLE, dead_vec == '0, "absorbed cell left in row")

endmodule

// ----- sv/isui_cell.sv -----
module isui_cell #(
  parameter int COORD_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  isui_pkg::cell_cmd_t          cmd,
  input  logic signed [COORD_BITS-1:0] req_lo,
  input  logic signed [COORD_BITS-1:0] req_hi,
  input  isui_pkg::cell_flags_t        left_flags,
  input  logic signed [COORD_BITS-1:0] left_start,
  input  logic signed [COORD_BITS-1:0] left_end,
  input  isui_pkg::cell_flags_t        right_flags,
  input  logic signed [COORD_BITS-1:0] right_start,
  input  logic signed [COORD_BITS-1:0] right_end,
  output isui_pkg::cell_flags_t        flags,
  output logic signed [COORD_BITS-1:0] start_q,
  output logic signed [COORD_BITS-1:0] end_q
);
  import isui_pkg::*;

  logic                         valid, valid_next;
  logic                         dead, dead_next;
  logic                         tail, tail_next;
  logic signed [COORD_BITS-1:0] start_next, end_next;
  logic                         covered, meet, place;

  assign covered = valid && (start_q <= req_lo) && (end_q >= req_hi);
  assign meet    = valid && (end_q >= req_lo) && (start_q <= req_hi);
  assign place   = !valid || (start_q > req_hi);

  assign flags = '{valid: valid, dead: dead, tail: tail,
                   covered: covered, meet: meet, place: place};

  always_comb begin
    valid_next = valid;
    dead_next  = dead;
    tail_next  = tail;
    start_next = start_q;
    end_next   = end_q;
    case (cmd)
      CMD_CLEAR: begin
        valid_next = 1'b0;
        dead_next  = 1'b0;
        tail_next  = 1'b0;
      end
      CMD_INSERT: begin
        // everything from the slot onward moves one place right
        if (place) begin
          if (left_flags.place) begin
            start_next = left_start;
            end_next   = left_end;
            valid_next = left_flags.valid;
          end else begin
            start_next = req_lo;
            end_next   = req_hi;
            valid_next = 1'b1;
          end
        end
      end
      CMD_MERGE: begin
        if (meet) begin
          if (!left_flags.meet) begin
            start_next = (start_q < req_lo) ? start_q : req_lo;
          end else begin
            dead_next = 1'b1;
          end
          if (!right_flags.meet) begin
            end_next = (end_q > req_hi) ? end_q : req_hi;
          end
        end
        tail_next = (meet && left_flags.meet) || place;
      end
      CMD_SQUEEZE: begin
        if (tail) begin
          start_next = right_start;
          end_next   = right_end;
          valid_next = right_flags.valid;
          dead_next  = right_flags.dead;
          tail_next  = right_flags.tail;
        end else if (right_flags.tail && right_flags.dead) begin
          // survivor takes over the end of the cell being dropped
          end_next = right_end;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      dead  <= 1'b0;
      tail  <= 1'b0;
    end else begin
      valid <= valid_next;
      dead  <= dead_next;
      tail  <= tail_next;
    end
    start_q <= start_next;
    end_q   <= end_next;
  end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import isui_pkg::*;

  localparam int          SLOTS          = 16;
  localparam int          ITEMS_PER_PASS = 575;
  localparam int          DRAIN_CYCLES   = 32;
  localparam int          IDLE_LIMIT     = 4000;
  localparam logic        FUNC_INSERT    = 1'b0;
  localparam logic        FUNC_CLEAR     = 1'b1;
  localparam logic [31:0] COORD_MIN      = 32'h8000_0000;
  localparam logic [31:0] COORD_MAX      = 32'h7FFF_FFFF;

  // one result beat, unpacked from m_tdata
  typedef struct packed {
    logic       added;
    logic [1:0] status;
    logic [4:0] stored;
  } set_reply_t;

  // one directed request; known marks a reply typed in by hand
  typedef struct packed {
    logic        func;
    logic [31:0] lo;
    logic [31:0] hi;
    logic        known;
    set_reply_t  reply;
  } request_row_t;

  localparam int DIRECTED_ROWS = 27;

  // extremes and refusals first, then a full table built out of order,
  // then the cases that only show with sixteen intervals held
  localparam request_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{FUNC_INSERT, COORD_MIN, COORD_MIN, 1'b1, '{1'b1, STATUS_OK, 5'd1}},
    '{FUNC_INSERT, COORD_MAX, COORD_MAX, 1'b1, '{1'b1, STATUS_OK, 5'd2}},
    '{FUNC_INSERT, 32'h0000_0005, 32'h0000_0003, 1'b1, '{1'b0, STATUS_ORDER, 5'd2}},
    '{FUNC_INSERT, COORD_MIN, COORD_MIN, 1'b1, '{1'b0, STATUS_OK, 5'd2}},
    '{FUNC_INSERT, COORD_MAX, COORD_MIN, 1'b1, '{1'b0, STATUS_ORDER, 5'd2}},
    '{FUNC_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{1'b0, STATUS_OK, 5'd0}},
    '{FUNC_INSERT, 32'h0014_0000, 32'h0015_0000, 1'b0, '0},
    '{FUNC_INSERT, 32'h0030_0000, 32'h0031_0000, 1'b0, '0},
    '{FUNC_INSERT, 32'h0000_0000, 32'h0001_0000, 1'b0, '0},
    '{FUNC_INSERT, 32'h0024_0000, 32'h0025_0000, 1'b0, '0},
    '{FUNC_INSERT, 32'h000C_0000, 32'h000D_0000, 1'b0, '0},
    '{FUNC_INSERT, 32'h0038_0000, 32'h0039_0000, 1'b0, '0},
    '{FUNC_INSERT, 32'h001C_0000, 32'h001D_0000, 1'b0, '0},
    '{FUNC_INSERT, 32'h0004_0000, 32'h0005_0000, 1'b0, '0},
    '{FUNC_INSERT, 32'h0028_0000, 32'h0029_0000, 1'b0, '0},
    '{FUNC_INSERT, 32'h003C_0000, 32'h003D_0000, 1'b0, '0},
    '{FUNC_INSERT, 32'h0008_0000, 32'h0009_0000, 1'b0, '0},
    '{FUNC_INSERT, 32'h0020_0000, 32'h0021_0000, 1'b0, '0},
    '{FUNC_INSERT, 32'h0034_0000, 32'h0035_0000, 1'b0, '0},
    '{FUNC_INSERT, 32'h0010_0000, 32'h0011_0000, 1'b0, '0},
    '{FUNC_INSERT, 32'h002C_0000, 32'h002D_0000, 1'b0, '0},
    '{FUNC_INSERT, 32'h0018_0000, 32'h0019_0000, 1'b0, '0},
    '{FUNC_INSERT, 32'hFFF0_0000, 32'hFFF8_0000, 1'b1, '{1'b0, STATUS_FULL, 5'd16}},
    '{FUNC_INSERT, 32'h0024_8000, 32'h0025_0000, 1'b1, '{1'b0, STATUS_OK, 5'd16}},
    '{FUNC_INSERT, 32'h0001_0000, 32'h0004_0000, 1'b0, '0},
    '{FUNC_INSERT, 32'h0005_0001, 32'h0007_FFFF, 1'b0, '0},
    '{FUNC_INSERT, COORD_MIN, COORD_MAX, 1'b1, '{1'b1, STATUS_OK, 5'd1}}
  };

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata  = '0;   // span_low [31:0], span_high [63:32]
  logic        s_tuser  = 1'b0; // func
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;         // added [0], status [2:1], stored_count [7:3]

  // shadow copy of the interval set, sorted by start in the low slots
  logic signed [31:0] span_start [SLOTS];
  logic signed [31:0] span_end   [SLOTS];
  int                 held_spans;

  set_reply_t pending_replies [$];
  int         mismatches   = 0;
  int         tx_idle_pct  = 0;
  int         rx_idle_pct  = 0;
  int         quiet_cycles = 0;

  interval_set_union_insert_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // work out the reply to one request and update the shadow set
  function automatic set_reply_t apply_request(input logic func, input logic [31:0] lo_raw,
                                               input logic [31:0] hi_raw);
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    int                 first;
    int                 past;
    int                 gone;
    set_reply_t         reply;
    lo = lo_raw;
    hi = hi_raw;
    reply = '{1'b0, STATUS_OK, 5'd0};
    if (func == FUNC_CLEAR) begin
      held_spans = 0;
      return reply;
    end
    if (lo > hi) begin
      reply.status = STATUS_ORDER;
      reply.stored = 5'(held_spans);
      return reply;
    end
    // already covered wins over a full table
    for (int i = 0; i < held_spans; i++) begin
      if (span_start[i] <= lo && span_end[i] >= hi) begin
        reply.stored = 5'(held_spans);
        return reply;
      end
    end
    // [first, past) are the stored intervals that meet the request, touching counts
    first = 0;
    while (first < held_spans && span_end[first] < lo) first++;
    past = first;
    while (past < held_spans && span_start[past] <= hi) past++;
    if (first == past) begin
      if (held_spans >= SLOTS) begin
        reply.status = STATUS_FULL;
        reply.stored = 5'(held_spans);
        return reply;
      end
      for (int i = held_spans; i > first; i--) begin
        span_start[i] = span_start[i-1];
        span_end[i]   = span_end[i-1];
      end
      span_start[first] = lo;
      span_end[first]   = hi;
      held_spans++;
    end else begin
      // union lands in the first slot hit, the rest close up behind it
      if (lo < span_start[first]) span_start[first] = lo;
      span_end[first] = (span_end[past-1] > hi) ? span_end[past-1] : hi;
      gone = past - first - 1;
      for (int i = first + 1; i + gone < held_spans; i++) begin
        span_start[i] = span_start[i+gone];
        span_end[i]   = span_end[i+gone];
      end
      held_spans -= gone;
    end
    reply.added  = 1'b1;
    reply.stored = 5'(held_spans);
    return reply;
  endfunction

  // offer one beat after a random gap; on acceptance queue what should come back
  task automatic send_request(input logic func, input logic [31:0] lo, input logic [31:0] hi,
                              input logic known, input set_reply_t reply);
    set_reply_t predicted;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= {hi, lo};
    do @(posedge clk); while (!s_tready);
    predicted = apply_request(func, lo, hi);
    pending_replies.insert(pending_replies.size(), known ? reply : predicted);
  endtask

  // hold the sender off until every reply has come back
  task automatic drain_replies();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input set_reply_t want,
                                 input set_reply_t got);
    if (mismatches < 10)
      $display({"[%0t] %s: expected added=%0d status=%0d count=%0d, ",
                "got added=%0d status=%0d count=%0d"},
               $time, what, want.added, want.status, want.stored,
               got.added, got.status, got.stored);
    mismatches++;
  endtask

  // receiver stalls at random, rate set per pass
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // result beats against the oldest expectation, field by field
  always @(posedge clk) begin
    set_reply_t got;
    set_reply_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = '{m_tdata[0], m_tdata[2:1], m_tdata[7:3]};
      if (pending_replies.size() == 0) begin
        report_mismatch("result beat with nothing outstanding", '0, got);
      end else begin
        want = pending_replies.pop_front();
        if (got.added !== want.added || got.status !== want.status
            || got.stored !== want.stored)
          report_mismatch("result beat differs", want, got);
      end
    end
  end

  // watchdog on cycles in which no beat moves on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("interval_set_union_insert_unit verification failed");
        $finish;
      end
    end
  end

  initial begin
    int          mode;
    int          unit;
    int          base;
    int          width_units;
    logic        func;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] swap;
    held_spans = 0;
    for (int i = 0; i < SLOTS; i++) begin
      span_start[i] = '0;
      span_end[i]   = '0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int pass = 0; pass < 3; pass++) begin
      // receiver idles more first, then the sender, then neither
      case (pass)
        0: begin
          tx_idle_pct = 26;
          rx_idle_pct = 64;
        end
        1: begin
          tx_idle_pct = 64;
          rx_idle_pct = 26;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase

      if (pass == 0) begin
        for (int r = 0; r < DIRECTED_ROWS; r++)
          send_request(DIRECTED[r].func, DIRECTED[r].lo, DIRECTED[r].hi,
                       DIRECTED[r].known, DIRECTED[r].reply);
        drain_replies();
      end

      for (int n = 0; n < ITEMS_PER_PASS; n++) begin
        mode = $urandom_range(0, 99);
        func = FUNC_INSERT;
        if (mode < 2) begin
          // rare clear so the set gets time to fill up
          func = FUNC_CLEAR;
          lo   = $urandom;
          hi   = $urandom;
        end else if (mode < 8) begin
          // raw words: every bit toggles, half of them out of order
          lo = $urandom;
          hi = $urandom;
        end else begin
          // dense grid so that covers, touches and merges are common
          unit        = ($urandom_range(0, 3) == 0) ? 1 : 32'h0001_0000;
          base        = $urandom_range(0, 127) - 64;
          width_units = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40)
                                                    : $urandom_range(0, 2);
          lo = 32'(base * unit);
          hi = 32'((base + width_units) * unit);
          if ($urandom_range(0, 9) == 0) begin
            swap = lo;
            lo   = hi;
            hi   = swap;
          end
        end
        send_request(func, lo, hi, 1'b0, '0);
        if (n % 200 == 199) drain_replies();
      end
      drain_replies();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_replies.size() == 0) begin
      $display("interval_set_union_insert_unit verification clean");
    end else begin
      $display("interval_set_union_insert_unit verification failed");
    end
    $finish;
  end

endmodule
